// ===== design/rfa_pkg.sv =====
// shared types, codes and widths of the rational fraction alu
`timescale 1ns / 1ps
`default_nettype none
package rfa_pkg;

    // default operand width and the fixed result field widths
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int KIND_W            = 3;
    localparam int RES_NUM_W         = 33;
    localparam int RES_DEN_W         = 31;
    localparam int FLAGS_W           = 2;

    // operation codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        K_ADD = 3'd0,
        K_SUB = 3'd1,
        K_MUL = 3'd2,
        K_DIV = 3'd3,
        K_CMP = 3'd4,
        K_RED = 3'd5
    } t_kind;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== design/rational_fraction_alu_core.sv =====
// rational fraction alu: top level, sequencer and result register
//
// One operation on two fractions a = a_num/a_den and b = b_num/b_den per beat.
// Input beat (s_*): s_tuser carries the operation (add, subtract, multiply,
// divide, compare, reduce a), s_tdata the four operands. Output beat (m_*):
// m_tdata carries res_num and res_den, m_tuser the greater and status flags.
// cfg_valid/cfg_data writes the auto_reduce bit; write it only while idle.
// From accept to the result register, an error item goes straight to S_OUT;
// otherwise the item passes S_MUL0, S_MUL1, S_MUL2 and S_SUM and, when the
// result is reduced, S_GCD (binary gcd, one shift or subtract per cycle), then
// S_DIVN and S_DIVD (the numerator and denominator divided by the gcd); the
// next beat can be taken in the cycle after the result loads. One gcd unit,
// one divider and one multiplier used three times do the arithmetic.
// One item at a time: s_tready is high only while the sequencer is idle.
// The result register lets the next item start while a result waits; if the
// receiver stalls, the finished item holds in the sequencer until it drains.
// Reset (synchronous, active low) clears auto_reduce and drops all valids.
`timescale 1ns / 1ps
`default_nettype none
module rational_fraction_alu_core #(
    parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input stream
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // a_num, a_den, b_num, b_den, zero pad
    input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      s_tdata,
    // kind
    input  wire logic [rfa_pkg::KIND_W-1:0]                s_tuser,
    // result stream
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // res_num, res_den
    output logic [rfa_pkg::RES_NUM_W+rfa_pkg::RES_DEN_W-1:0] m_tdata,
    // greater, status
    output logic [rfa_pkg::FLAGS_W-1:0]                    m_tuser,
    // configuration write
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic                                      cfg_data
);

    localparam int W     = OPERAND_WIDTH;
    localparam int M     = 2 * OPERAND_WIDTH;
    localparam int NUM_W = rfa_pkg::RES_NUM_W;
    localparam int DEN_W = rfa_pkg::RES_DEN_W;

    rfa_pkg::t_state r_state, n_state;

    logic             r_auto;
    logic [2:0]       r_kind;
    logic             r_err;
    logic             r_an_neg, r_ad_neg, r_bn_neg, r_bd_neg;
    logic [W-1:0]     r_an, r_ad, r_bn, r_bd;
    logic [M-1:0]     r_p0, r_p1;
    logic             r_num_neg;
    logic [M-1:0]     r_num, r_den;
    logic [M-1:0]     r_g;
    logic             r_out_valid;
    logic [NUM_W-1:0] r_res_num;
    logic [DEN_W-1:0] r_res_den;
    logic             r_greater;
    logic             r_status;

    logic             accept;
    logic [W-1:0]     in_an, in_ad, in_bn, in_bd;
    logic [2:0]       in_kind;
    logic             in_err;
    logic             out_load;
    logic             do_reduce;
    logic [W-1:0]     mul_a, mul_b;
    logic [M-1:0]     prod;
    logic             s0, s1, s2;
    logic [M-1:0]     sum_mag;
    logic             sum_neg;
    logic [M-1:0]     f_num, f_den;
    logic             f_num_neg, f_den_neg, f_neg;
    logic             gcd_start, gcd_done;
    logic [M-1:0]     gcd_val;
    logic             div_start, div_done;
    logic [M-1:0]     div_dividend, div_divisor, div_quot;
    logic signed [M:0] num_sv;

    // operand fields and error check at the input beat
    assign accept  = s_tvalid && s_tready;
    assign in_kind = s_tuser;
    assign in_an   = s_tdata[W-1:0];
    assign in_ad   = s_tdata[2*W-1:W];
    assign in_bn   = s_tdata[3*W-1:2*W];
    assign in_bd   = s_tdata[4*W-1:3*W];
    assign in_err  = (in_kind > rfa_pkg::K_RED) || (in_ad == '0)
                     || ((in_kind != rfa_pkg::K_RED) && (in_bd == '0))
                     || ((in_kind == rfa_pkg::K_DIV) && (in_bn == '0));

    assign out_load  = !r_out_valid || m_tready;
    assign do_reduce = r_auto || (r_kind == rfa_pkg::K_RED);
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            r_auto <= cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = in_err ? rfa_pkg::S_OUT : rfa_pkg::S_MUL0;
                end
            end
            rfa_pkg::S_MUL0: n_state = rfa_pkg::S_MUL1;
            rfa_pkg::S_MUL1: n_state = rfa_pkg::S_MUL2;
            rfa_pkg::S_MUL2: n_state = rfa_pkg::S_SUM;
            rfa_pkg::S_SUM:  n_state = do_reduce ? rfa_pkg::S_GCD : rfa_pkg::S_OUT;
            rfa_pkg::S_GCD: begin
                if (gcd_done) begin
                    n_state = rfa_pkg::S_DIVN;
                end
            end
            rfa_pkg::S_DIVN: begin
                if (div_done) begin
                    n_state = rfa_pkg::S_DIVD;
                end
            end
            rfa_pkg::S_DIVD: begin
                if (div_done) begin
                    n_state = rfa_pkg::S_OUT;
                end
            end
            rfa_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = rfa_pkg::S_IDLE;
                end
            end
            default: n_state = rfa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, unit starts, ready
    always_comb begin
        s_tready     = 1'b0;
        mul_a        = r_ad;
        mul_b        = (r_kind == rfa_pkg::K_DIV) ? r_bn : r_bd;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_den;
        div_divisor  = r_g;
        unique case (r_state)
            rfa_pkg::S_IDLE: s_tready = 1'b1;
            rfa_pkg::S_MUL0: begin
                mul_a = r_an;
                mul_b = (r_kind == rfa_pkg::K_MUL) ? r_bn : r_bd;
            end
            rfa_pkg::S_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            rfa_pkg::S_SUM:  gcd_start = do_reduce;
            rfa_pkg::S_GCD: begin
                div_start    = gcd_done;
                div_dividend = r_num;
                div_divisor  = gcd_val;
            end
            rfa_pkg::S_DIVN: div_start = div_done;
            default: ;
        endcase
    end

    // signs of the three products
    assign s0 = r_an_neg ^ ((r_kind == rfa_pkg::K_MUL) ? r_bn_neg : r_bd_neg);
    assign s1 = r_bn_neg ^ r_ad_neg ^ (r_kind != rfa_pkg::K_ADD);
    assign s2 = r_ad_neg ^ ((r_kind == rfa_pkg::K_DIV) ? r_bn_neg : r_bd_neg);

    // signed magnitude sum of the two cross products
    always_comb begin
        if (s0 == s1) begin
            sum_mag = r_p0 + r_p1;
            sum_neg = s0;
        end else if (r_p0 >= r_p1) begin
            sum_mag = r_p0 - r_p1;
            sum_neg = s0;
        end else begin
            sum_mag = r_p1 - r_p0;
            sum_neg = s1;
        end
    end

    // fraction before reduction, denominator sign moved into the numerator
    always_comb begin
        case (r_kind) inside
            rfa_pkg::K_ADD, rfa_pkg::K_SUB, rfa_pkg::K_CMP: begin
                f_num     = sum_mag;
                f_num_neg = sum_neg;
                f_den     = prod;
                f_den_neg = s2;
            end
            rfa_pkg::K_RED: begin
                f_num     = M'(r_an);
                f_num_neg = r_an_neg;
                f_den     = M'(r_ad);
                f_den_neg = r_ad_neg;
            end
            default: begin
                f_num     = r_p0;
                f_num_neg = s0;
                f_den     = prod;
                f_den_neg = s2;
            end
        endcase
        f_neg = (f_num_neg ^ f_den_neg) && (f_num != '0);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= in_kind;
            r_err    <= in_err;
            r_an_neg <= in_an[W-1];
            r_ad_neg <= in_ad[W-1];
            r_bn_neg <= in_bn[W-1];
            r_bd_neg <= in_bd[W-1];
            r_an     <= in_an[W-1] ? -in_an : in_an;
            r_ad     <= in_ad[W-1] ? -in_ad : in_ad;
            r_bn     <= in_bn[W-1] ? -in_bn : in_bn;
            r_bd     <= in_bd[W-1] ? -in_bd : in_bd;
        end
        if (r_state == rfa_pkg::S_MUL1) begin
            r_p0 <= prod;
        end
        if (r_state == rfa_pkg::S_MUL2) begin
            r_p1 <= prod;
        end
        if (r_state == rfa_pkg::S_SUM) begin
            r_num     <= f_num;
            r_num_neg <= f_neg;
            r_den     <= f_den;
        end
        if ((r_state == rfa_pkg::S_GCD) && gcd_done) begin
            r_g <= gcd_val;
        end
        if ((r_state == rfa_pkg::S_DIVN) && div_done) begin
            r_num <= div_quot;
        end
        if ((r_state == rfa_pkg::S_DIVD) && div_done) begin
            r_den <= div_quot;
        end
    end

    // shared units
    rfa_mul #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    rfa_gcd #(
        .WIDTH (M)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (f_num),
        .i_y     (f_den),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    rfa_div #(
        .WIDTH (M)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // signed numerator, wrapped to the result field
    assign num_sv = r_num_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == rfa_pkg::S_OUT) && out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rfa_pkg::S_OUT) && out_load) begin
            if (r_err) begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_greater <= 1'b0;
                r_status  <= 1'b1;
            end else begin
                r_res_num <= NUM_W'(num_sv);
                r_res_den <= DEN_W'(r_den);
                r_greater <= (r_kind == rfa_pkg::K_CMP) && !r_num_neg && (r_num != '0);
                r_status  <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_res_den, r_res_num};
    assign m_tuser  = {r_status, r_greater};

    // an error result carries an all-zero fraction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("error result with nonzero fraction");

    // greater never comes with an error or a non-positive numerator
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tdata[NUM_W-1] && (m_tdata[NUM_W-1:0] != '0))
        else $error("greater flag inconsistent with result");

    // a rejected item skips the arithmetic
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_err |=> r_state == rfa_pkg::S_OUT)
        else $error("error item entered the datapath");

    // gcd completion hands over to the numerator division
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfa_pkg::S_GCD) && gcd_done |=> (r_state == rfa_pkg::S_DIVN) && !div_done)
        else $error("divider not started after gcd");

endmodule
`default_nettype wire

// ===== design/rfa_mul.sv =====
// unsigned magnitude multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module rfa_mul #(
    parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic [OPERAND_WIDTH-1:0]   i_a,
    input  wire logic [OPERAND_WIDTH-1:0]   i_b,
    output logic      [2*OPERAND_WIDTH-1:0] o_prod
);

    logic [2*OPERAND_WIDTH-1:0] r_prod;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== design/rfa_gcd.sv =====
// binary gcd unit, one shift or subtract step per cycle
`timescale 1ns / 1ps
`default_nettype none
module rfa_gcd #(
    parameter int WIDTH = 2 * rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic      [WIDTH-1:0] o_gcd
);

    localparam int K_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [K_W-1:0]   r_k;
    logic [WIDTH-1:0] r_gcd;
    logic             finish;

    // finished once either operand reaches zero
    assign finish = r_busy && ((r_a == '0) || (r_b == '0));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: strip common twos, then subtract odd values
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_x;
            r_b <= i_y;
            r_k <= '0;
        end else if (r_busy) begin
            if (r_a == '0) begin
                r_gcd <= r_b << r_k;
            end else if (r_b == '0) begin
                r_gcd <= r_a << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_gcd;

endmodule
`default_nettype wire

// ===== design/rfa_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rfa_div #(
    parameter int WIDTH = 2 * rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic      [WIDTH-1:0] o_quot
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // trial subtract of the shifted partial remainder
    assign rem_sh = {r_rem, r_quo[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                r_rem <= diff[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ===== tb/rational_fraction_alu_core_tb.sv =====
// self-checking testbench: fraction operations streamed through the alu and compared per field
`timescale 1ns / 1ps
module rational_fraction_alu_core_tb;

    localparam int OPW         = rfa_pkg::OPERAND_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SINK_HOLD   = 900;
    localparam int HOLD_AT     = 200;
    localparam int RAND_PHASE  = 440;
    localparam int SETTLE      = 300;
    // kinds the block does not define, answered with an error result
    localparam logic [rfa_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [rfa_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct {
        logic [rfa_pkg::KIND_W-1:0] kind;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } t_op;

    typedef struct {
        logic [rfa_pkg::RES_NUM_W-1:0] num;
        logic [rfa_pkg::RES_DEN_W-1:0] den;
        logic greater;
        logic status;
    } t_fraction;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [4*OPW-1:0] s_tdata = '0;
    logic [rfa_pkg::KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rfa_pkg::RES_NUM_W+rfa_pkg::RES_DEN_W-1:0] m_tdata;
    logic [rfa_pkg::FLAGS_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    t_op pending_ops[$];
    t_fraction pending_results[$];
    t_op cur_op;
    bit reduce_cfg = 1'b0;
    bit sender_steady = 1'b0;
    bit sink_steady = 1'b0;
    int ops_sent = 0;
    int results_checked = 0;
    int sink_hold_left = 0;
    int idle_cycles = 0;
    int errors = 0;

    always #4 i_clk = ~i_clk;

    rational_fraction_alu_core #(.OPERAND_WIDTH(OPW)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // euclid on non-negative values
    function automatic longint gcd_mag(longint x, longint y);
        longint t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // expected result of one operation, in plain signed arithmetic
    function automatic t_fraction predict_fraction(t_op op, bit reduce_on);
        t_fraction r;
        longint an, ad, bn, bd, num, den, g;
        bit bad;
        bit do_reduce;
        r = '{num: '0, den: '0, greater: 1'b0, status: 1'b0};
        an = op.a_num;
        ad = op.a_den;
        bn = op.b_num;
        bd = op.b_den;
        num = 0;
        den = 1;
        bad = 1'b0;
        do_reduce = reduce_on;
        case (op.kind) inside
            rfa_pkg::K_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            rfa_pkg::K_SUB, rfa_pkg::K_CMP: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            rfa_pkg::K_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            rfa_pkg::K_DIV: begin
                if (bn == 0) bad = 1'b1;
                num = an * bd;
                den = ad * bn;
            end
            rfa_pkg::K_RED: begin
                num = an;
                den = ad;
                do_reduce = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (ad == 0 || (op.kind != rfa_pkg::K_RED && bd == 0)) bad = 1'b1;
        if (bad) begin
            r.status = 1'b1;
            return r;
        end
        // sign lives in the numerator
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (do_reduce) begin
            g = gcd_mag(num < 0 ? -num : num, den);
            num = num / g;
            den = den / g;
        end
        r.num = 33'(num);
        r.den = 31'(den);
        r.greater = (op.kind == rfa_pkg::K_CMP) && (num > 0);
        return r;
    endfunction

    task automatic add_op(logic [rfa_pkg::KIND_W-1:0] kind, int an, int ad, int bn, int bd);
        t_op op;
        op.kind = kind;
        op.a_num = 16'(an);
        op.a_den = 16'(ad);
        op.b_num = 16'(bn);
        op.b_den = 16'(bd);
        pending_ops.push_back(op);
    endtask

    // extremes, full-range random values, small values and values sharing a common factor
    function automatic int pick_operand(int factor);
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 1;
                    default: v = 0;
                endcase
            end
            1, 2, 3: begin
                v = $urandom;
                v = int'($signed(v[15:0]));
            end
            4, 5, 6: v = int'($urandom_range(0, 120)) - 60;
            default: v = (int'($urandom_range(0, 300)) - 150) * factor;
        endcase
        return v;
    endfunction

    task automatic load_directed();
        add_op(rfa_pkg::K_ADD, 1, 2, 1, 3);
        add_op(rfa_pkg::K_SUB, 1, 2, 3, 4);
        add_op(rfa_pkg::K_MUL, -3, 4, 2, -5);
        add_op(rfa_pkg::K_DIV, 3, 4, -5, 6);
        add_op(rfa_pkg::K_CMP, 1, 2, 1, 3);
        add_op(rfa_pkg::K_CMP, 2, 4, 1, 2);
        add_op(rfa_pkg::K_CMP, 1, -2, -1, 3);
        add_op(rfa_pkg::K_RED, 6, -8, 0, 0);
        add_op(rfa_pkg::K_RED, 0, -7, 5, 9);
        add_op(rfa_pkg::K_RED, -32768, -32768, 1, 0);
        add_op(rfa_pkg::K_ADD, 1, 0, 1, 3);
        add_op(rfa_pkg::K_MUL, 1, 3, 2, 0);
        add_op(rfa_pkg::K_DIV, 5, 7, 0, 9);
        add_op(KIND_SPARE_A, 1, 2, 3, 4);
        add_op(KIND_SPARE_B, 1, 2, 3, 4);
        add_op(rfa_pkg::K_ADD, -32768, -32768, 32767, -32768);
        add_op(rfa_pkg::K_MUL, -32768, 1, -32768, 1);
        add_op(rfa_pkg::K_DIV, 32767, -32768, -32768, 32767);
        add_op(rfa_pkg::K_SUB, -32768, 32767, 32767, -32768);
        add_op(rfa_pkg::K_CMP, -32768, 1, 32767, 1);
        add_op(rfa_pkg::K_ADD, 0, 5, 0, -3);
        add_op(rfa_pkg::K_RED, 4, 0, 1, 1);
        add_op(rfa_pkg::K_MUL, 0, -4, 7, -9);
        add_op(rfa_pkg::K_SUB, 32767, -1, -32768, -1);
    endtask

    task automatic load_random(int count);
        int factor;
        logic [rfa_pkg::KIND_W-1:0] kind;
        repeat (count) begin
            factor = $urandom_range(1, 200);
            if ($urandom_range(0, 99) < 4)
                kind = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;
            else
                kind = 3'($urandom_range(0, 5));
            add_op(kind, pick_operand(factor), pick_operand(factor),
                   pick_operand(factor), pick_operand(factor));
        end
    endtask

    // waits until every queued operation is sent and has its result back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ops.size() != 0 || results_checked != ops_sent);
    endtask

    task automatic write_auto_reduce(bit value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reduce_cfg = value;
    endtask

    // input driver: one beat offered at a time from the pending operations
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_fraction(cur_op, reduce_cfg));
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 &&
                    (sender_steady || $urandom_range(0, 99) >= 36)) begin
                    cur_op = pending_ops.pop_front();
                    ops_sent++;
                    s_tdata <= {cur_op.b_den, cur_op.b_num, cur_op.a_den, cur_op.a_num};
                    s_tuser <= cur_op.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_fraction want;
        t_fraction got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.num = m_tdata[rfa_pkg::RES_NUM_W-1:0];
                got.den = m_tdata[rfa_pkg::RES_NUM_W+rfa_pkg::RES_DEN_W-1:rfa_pkg::RES_NUM_W];
                got.greater = m_tuser[0];
                got.status = m_tuser[1];
                if (pending_results.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.num !== want.num) begin
                        $error("res_num: expected %0d actual %0d",
                               $signed(want.num), $signed(got.num));
                        errors++;
                    end
                    if (got.den !== want.den) begin
                        $error("res_den: expected %0d actual %0d", want.den, got.den);
                        errors++;
                    end
                    if (got.greater !== want.greater) begin
                        $error("greater: expected %0d actual %0d", want.greater, got.greater);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                end
                results_checked++;
                // one long back-pressure stretch so the block fills and stalls its input
                if (results_checked == HOLD_AT) sink_hold_left = SINK_HOLD;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= sink_steady || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sequence of phases, register written only between drained phases
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_auto_reduce(1'b0);
        load_directed();
        wait_drained();
        write_auto_reduce(1'b1);
        load_directed();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            write_auto_reduce(p % 2 == 0);
            sender_steady = (p == 2);
            sink_steady = (p == 2);
            load_random(RAND_PHASE);
            wait_drained();
        end
        sender_steady = 1'b0;
        sink_steady = 1'b0;

        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rfa_pkg.sv
design/rfa_mul.sv
design/rfa_gcd.sv
design/rfa_div.sv
design/rational_fraction_alu_core.sv
tb/rational_fraction_alu_core_tb.sv
